// ===== src/assert_macros.svh =====
// Shared assertion macros; every check is clocked on clock and off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Trigger at one edge implies a property at the next edge.
`define ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ===== src/salc_pkg.sv =====
package salc_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int STAMP_W    = 32;
   localparam int TALLY_W    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 2'd2;

   localparam logic [1:0] ACT_LOAD   = 2'd1;
   localparam logic [1:0] ACT_MODIFY = 2'd2;

   localparam logic [1:0] OUT_NONE  = 2'd0;
   localparam logic [1:0] OUT_HIT   = 2'd1;
   localparam logic [1:0] OUT_FILL  = 2'd2;
   localparam logic [1:0] OUT_EVICT = 2'd3;

   typedef struct packed {
      logic [2:0] set_bits;
      logic [3:0] ways;
      logic [4:0] offset;
   } csr_type;

   typedef struct packed {
      logic access;
      logic modify;
   } job_ctl_type;

endpackage

// ===== src/salc_ifs.sv =====
interface salc_req_if #(
   parameter int ADDR_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [ADDR_BITS-1:0] address;

   modport source (output valid, output action, output address, input ready);
   modport sink (input valid, input action, input address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         outcome;
   logic               extra_hit;
   logic [TALLY_W-1:0] hits_total;
   logic [TALLY_W-1:0] misses_total;
   logic [TALLY_W-1:0] evictions_total;

   modport source (output valid, output outcome, output extra_hit, output hits_total,
                   output misses_total, output evictions_total, input ready);
   modport sink (input valid, input outcome, input extra_hit, input hits_total,
                 input misses_total, input evictions_total, output ready);
endinterface

// ===== src/salc_ram.sv =====
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/salc_front.sv =====
module salc_front import salc_pkg::*; #(
   parameter int ADDR_BITS    = 32,
   parameter int MAX_SET_BITS = 6,
   localparam int ROW_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   salc_req_if.sink             req,
   input  csr_type              csr,
   input  logic                 hold,
   input  logic                 q_full,
   output logic                 push,
   output job_ctl_type          job_ctl,
   output logic [ROW_AW-1:0]    job_set,
   output logic [ADDR_BITS-1:0] job_tag,
   output logic [STAMP_W-1:0]   job_stamp
);

   logic [STAMP_W-1:0]   stamp_ff;
   logic [STAMP_W-1:0]   stamp_in;
   logic [2:0]           sbits;
   logic [ADDR_BITS-1:0] above;
   logic [5:0]           tag_shift;
   logic [ROW_AW-1:0]    set_mask;

   assign req.ready = !hold && !q_full;
   assign push      = req.valid && req.ready;

   always_comb begin
      if (32'(csr.set_bits) > 32'(MAX_SET_BITS)) begin
         sbits = 3'(MAX_SET_BITS);
      end else begin
         sbits = csr.set_bits;
      end
      above          = req.address >> csr.offset;
      tag_shift      = {1'b0, csr.offset} + {3'b000, sbits};
      set_mask       = ~({ROW_AW{1'b1}} << sbits);
      job_set        = above[ROW_AW-1:0] & set_mask;
      job_tag        = req.address >> tag_shift;
      job_ctl.access = (req.action == ACT_LOAD) || (req.action == ACT_MODIFY);
      job_ctl.modify = (req.action == ACT_MODIFY);
      stamp_in       = stamp_ff + STAMP_W'(1);
      job_stamp      = stamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else if (push) begin
         stamp_ff <= stamp_in;
      end
   end

endmodule

// ===== src/salc_queue.sv =====
`include "assert_macros.svh"

module salc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign dout      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   `ASSERT_CLK(a_q_no_overflow, push |-> !full, "push into full request queue")
   `ASSERT_CLK(a_q_no_underflow, pop |-> not_empty, "pop from empty request queue")

endmodule

// ===== src/salc_back.sv =====
`include "assert_macros.svh"

module salc_back import salc_pkg::*; #(
   parameter int ADDR_BITS    = 32,
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   localparam int ROW_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           csr_ways,
   input  logic                 q_valid,
   input  job_ctl_type          q_ctl,
   input  logic [ROW_AW-1:0]    q_set,
   input  logic [ADDR_BITS-1:0] q_tag,
   input  logic [STAMP_W-1:0]   q_stamp,
   output logic                 q_pop,
   output logic                 clearing,
   salc_rsp_if.source           rsp
);

   localparam int ROWS  = 1 << MAX_SET_BITS;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] tag;
      logic [STAMP_W-1:0]   stamp;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] v,
                                                  input logic [1:0] n);
      logic [TALLY_W:0] sum;
      sum = {1'b0, v} + (TALLY_W + 1)'(n);
      return sum[TALLY_W] ? '1 : sum[TALLY_W-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [ROW_AW-1:0]    clr_ff, clr_in;
   job_ctl_type          ctl_ff, ctl_in;
   logic [ROW_AW-1:0]    set_ff, set_in;
   logic [ADDR_BITS-1:0] tag_ff, tag_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   row_type              row_ff, row_in;
   logic [WAY_W-1:0]     way_ff, way_in;
   logic [WAY_W-1:0]     scan_ff, scan_in;
   logic [1:0]           outcome_ff, outcome_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_outcome_ff, rsp_outcome_in;
   logic                 rsp_extra_ff, rsp_extra_in;
   logic [TALLY_W-1:0]   hits_ff, hits_in;
   logic [TALLY_W-1:0]   misses_ff, misses_in;
   logic [TALLY_W-1:0]   evicts_ff, evicts_in;

   logic [CNT_W-1:0]     ways_eff;
   logic                 hit;
   logic [WAY_W-1:0]     hit_way;
   logic                 inv;
   logic [WAY_W-1:0]     inv_way;
   row_type              row_rd;
   row_type              row_wr;
   logic                 ram_we;
   logic [ROW_AW-1:0]    ram_waddr;
   logic [ROW_W-1:0]     ram_wdata;
   logic                 ram_re;
   logic [ROW_AW-1:0]    ram_raddr;
   logic [ROW_W-1:0]     ram_rdata;
   logic                 rsp_load;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign row_rd   = ram_rdata;
   assign clearing = (state_ff == ST_CLEAR);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.outcome         = rsp_outcome_ff;
   assign rsp.extra_hit       = rsp_extra_ff;
   assign rsp.hits_total      = hits_ff;
   assign rsp.misses_total    = misses_ff;
   assign rsp.evictions_total = evicts_ff;

   // way count clamp and set compare
   always_comb begin
      if (csr_ways == '0) begin
         ways_eff = CNT_W'(1);
      end else if (32'(csr_ways) > 32'(MAX_WAYS)) begin
         ways_eff = CNT_W'(MAX_WAYS);
      end else begin
         ways_eff = CNT_W'(csr_ways);
      end
      hit     = 1'b0;
      hit_way = '0;
      inv     = 1'b0;
      inv_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (CNT_W'(w) < ways_eff) begin
            if (row_rd[w].valid && (row_rd[w].tag == tag_ff)) begin
               hit     = 1'b1;
               hit_way = WAY_W'(w);
            end
            if (!row_rd[w].valid) begin
               inv     = 1'b1;
               inv_way = WAY_W'(w);
            end
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      ctl_in         = ctl_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      stamp_in       = stamp_ff;
      row_in         = row_ff;
      way_in         = way_ff;
      scan_in        = scan_ff;
      outcome_in     = outcome_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_extra_in   = rsp_extra_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      evicts_in      = evicts_ff;
      q_pop          = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = q_set;
      ram_we         = 1'b0;
      ram_waddr      = set_ff;
      row_wr         = row_ff;
      row_wr[way_ff] = '{valid: 1'b1, tag: tag_ff, stamp: stamp_ff};
      ram_wdata      = row_wr;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ROW_AW'(1);
            if (clr_ff == ROW_AW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ram_re   = 1'b1;
               ctl_in   = q_ctl;
               set_in   = q_set;
               tag_in   = q_tag;
               stamp_in = q_stamp;
               if (q_ctl.access) begin
                  state_in = ST_LOOK;
               end else begin
                  outcome_in = OUT_NONE;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_LOOK: begin
            row_in  = row_rd;
            way_in  = '0;
            scan_in = WAY_W'(1);
            if (hit) begin
               way_in     = hit_way;
               outcome_in = OUT_HIT;
               state_in   = ST_DONE;
            end else if (inv) begin
               way_in     = inv_way;
               outcome_in = OUT_FILL;
               state_in   = ST_DONE;
            end else if (ways_eff == CNT_W'(1)) begin
               outcome_in = OUT_EVICT;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // LRU: strict less keeps the lowest way on a tie
            if (row_ff[scan_ff].stamp < row_ff[way_ff].stamp) begin
               way_in = scan_ff;
            end
            scan_in = scan_ff + WAY_W'(1);
            if (CNT_W'(scan_ff) == ways_eff - CNT_W'(1)) begin
               outcome_in = OUT_EVICT;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               ram_we         = (outcome_ff != OUT_NONE);
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_extra_in   = ctl_ff.modify;
               hits_in        = sat_add(hits_ff, {1'b0, outcome_ff == OUT_HIT}
                                                 + {1'b0, ctl_ff.modify});
               misses_in      = sat_add(misses_ff, {1'b0, (outcome_ff == OUT_FILL)
                                                          || (outcome_ff == OUT_EVICT)});
               evicts_in      = sat_add(evicts_ff, {1'b0, outcome_ff == OUT_EVICT});
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff         <= ctl_in;
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      stamp_ff       <= stamp_in;
      row_ff         <= row_in;
      way_ff         <= way_in;
      scan_ff        <= scan_in;
      outcome_ff     <= outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_extra_ff   <= rsp_extra_in;
   end

   `ASSERT_CLK(a_evict_le_miss, evicts_ff <= misses_ff, "eviction total above miss total")
   `ASSERT_CLK(a_scan_full_set, (state_ff == ST_SCAN) |-> row_ff[0].valid, "LRU scan on open set")
   `ASSERT_NEXT(a_done_rsp, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "response not loaded")

endmodule

// ===== src/set_assoc_lru_cache_sim.sv =====
// channel    dir   carries                                          handshake
// req_chan   in    action, address                                  valid / ready
// rsp_chan   out   outcome, extra_hit, hits/misses/evictions_total  valid / ready
// csr        in    csr_index, csr_wdata                             csr_we
//
// Per request the back end FSM does one tag RAM row read, then for an eviction an LRU scan of one way per cycle,
// then one row write (none for a non-access request) as it loads the response register.
// Reset is synchronous; afterwards the tag RAM is cleared one set per cycle over all
// 2^MAX_SET_BITS sets, req_chan.ready low meanwhile.
// A two-entry request queue sits between front and back; the response register holds until taken.
`include "assert_macros.svh"

module set_assoc_lru_cache_sim import salc_pkg::*; #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   salc_req_if.sink              req_chan,
   salc_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROW_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int JOB_W  = $bits(job_ctl_type) + ROW_AW + ADDR_BITS + STAMP_W;
   localparam int Q_DEPTH = 2;

   csr_type              csr_ff, csr_in;
   logic                 push;
   logic                 q_full;
   logic                 q_valid;
   logic                 q_pop;
   logic                 clearing;
   job_ctl_type          f_ctl, q_ctl;
   logic [ROW_AW-1:0]    f_set, q_set;
   logic [ADDR_BITS-1:0] f_tag, q_tag;
   logic [STAMP_W-1:0]   f_stamp, q_stamp;
   logic [JOB_W-1:0]     q_din, q_dout;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS: csr_in.set_bits = csr_wdata[2:0];
            CSR_WAYS:     csr_in.ways     = csr_wdata[3:0];
            CSR_OFFSET:   csr_in.offset   = csr_wdata[4:0];
            default:      csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{set_bits: 3'd0, ways: 4'd1, offset: 5'd0};
      end else begin
         csr_ff <= csr_in;
      end
   end

   salc_front #(
      .ADDR_BITS    (ADDR_BITS),
      .MAX_SET_BITS (MAX_SET_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr       (csr_ff),
      .hold      (clearing),
      .q_full    (q_full),
      .push      (push),
      .job_ctl   (f_ctl),
      .job_set   (f_set),
      .job_tag   (f_tag),
      .job_stamp (f_stamp)
   );

   assign q_din = {f_ctl, f_set, f_tag, f_stamp};
   assign {q_ctl, q_set, q_tag, q_stamp} = q_dout;

   salc_queue #(
      .WIDTH (JOB_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din       (q_din),
      .full      (q_full),
      .pop       (q_pop),
      .dout      (q_dout),
      .not_empty (q_valid)
   );

   salc_back #(
      .ADDR_BITS    (ADDR_BITS),
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_ways (csr_ff.ways),
      .q_valid  (q_valid),
      .q_ctl    (q_ctl),
      .q_set    (q_set),
      .q_tag    (q_tag),
      .q_stamp  (q_stamp),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp      (rsp_chan)
   );

   `ASSERT_CLK(a_no_accept_in_clear, clearing |-> !push, "request taken during tag clear")

endmodule
